// ----- hw/rtl/tli_pkg.sv -----
// Shared widths, reset values and stage types for the triangle linear interpolator.
// No dependencies; used by triangle_linear_interpolator_top.
package tli_pkg;

  localparam int unsigned FIELD_W   = 32;
  localparam int unsigned IN_W      = 11 * FIELD_W;
  localparam int unsigned DIFF_W    = FIELD_W + 1;
  localparam int unsigned PROD_W    = 2 * DIFF_W;
  localparam int unsigned DET_W     = PROD_W + 1;
  localparam int unsigned SPLIT_W   = 34;
  localparam int unsigned LO_SUM_W  = 70;
  localparam int unsigned HI_SUM_W  = 68;
  localparam int unsigned NUM_W     = HI_SUM_W + SPLIT_W;
  localparam int unsigned DIV_N_W   = NUM_W + 2;
  localparam int unsigned DIV_D_W   = DET_W + 1;
  localparam int unsigned Q_W       = 32;
  localparam int unsigned FRONT_STAGES = 9;
  localparam int unsigned PIPE_STAGES  = FRONT_STAGES + Q_W;

  localparam logic [31:0] THR_RESET = 32'd4295;
  localparam logic [31:0] SAT_POS   = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG   = 32'h8000_0000;

  typedef struct packed {
    logic [DIV_N_W-1:0] rem;
    logic [DIV_D_W-1:0] dd;
    logic [Q_W-1:0]     q;
    logic               neg;
    logic               degen;
    logic               ovf;
  } div_t;

endpackage

// ----- hw/rtl/triangle_linear_interpolator_top.sv -----
// Top level of the triangle linear interpolator: fits a plane through three vertices
// and evaluates it at a query point. Depends on tli_pkg.
//
//  channel  dir  width  contents
//  s_*      in   352    three vertices (x, y, value) and query x, y
//  m_*      out  32+1   interpolated value, degenerate flag in tuser
//  cfg_*    in   32     degenerate threshold
//
// One item enters per cycle while s_tready is high, that is while the skid register is empty.
// The depth is set by 9 arithmetic stages and a 32-stage restoring divider,
// one quotient bit per stage. A skid register behind the output register holds
// one item when the sink stalls, and the whole pipe then freezes until it drains.
// Reset empties the pipe and loads the threshold with its default.
module triangle_linear_interpolator_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // v0_x, v0_y, v0_value, v1_x, v1_y, v1_value, v2_x, v2_y, v2_value, q_x, q_y
  input  logic [351:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // interpolated_value
  output logic [31:0]  m_tdata,
  // degenerate
  output logic         m_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data
);

  logic [31:0] thr;
  logic [tli_pkg::PIPE_STAGES-1:0] v;
  logic adv;
  logic skid_valid;
  logic [31:0] skid_data;
  logic skid_user;

  assign adv       = !skid_valid;
  assign s_tready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= tli_pkg::THR_RESET;
    end else if (cfg_valid) begin
      thr <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[tli_pkg::PIPE_STAGES-2:0], s_tvalid};
    end
  end

  // Stage 0: differences against vertex 0.
  logic signed [31:0] x0, y0, f0, x1, y1, f1, x2, y2, f2, qx, qy;
  assign x0 = $signed(s_tdata[31:0]);
  assign y0 = $signed(s_tdata[63:32]);
  assign f0 = $signed(s_tdata[95:64]);
  assign x1 = $signed(s_tdata[127:96]);
  assign y1 = $signed(s_tdata[159:128]);
  assign f1 = $signed(s_tdata[191:160]);
  assign x2 = $signed(s_tdata[223:192]);
  assign y2 = $signed(s_tdata[255:224]);
  assign f2 = $signed(s_tdata[287:256]);
  assign qx = $signed(s_tdata[319:288]);
  assign qy = $signed(s_tdata[351:320]);

  logic signed [32:0] s0_dx1, s0_dy1, s0_dx2, s0_dy2, s0_dqx, s0_dqy, s0_df1, s0_df2;
  logic signed [31:0] s0_f0;

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_dx1 <= {x1[31], x1} - {x0[31], x0};
      s0_dy1 <= {y1[31], y1} - {y0[31], y0};
      s0_dx2 <= {x2[31], x2} - {x0[31], x0};
      s0_dy2 <= {y2[31], y2} - {y0[31], y0};
      s0_dqx <= {qx[31], qx} - {x0[31], x0};
      s0_dqy <= {qy[31], qy} - {y0[31], y0};
      s0_df1 <= {f1[31], f1} - {f0[31], f0};
      s0_df2 <= {f2[31], f2} - {f0[31], f0};
      s0_f0  <= f0;
    end
  end

  // Stage 1: the six cross products.
  logic signed [65:0] s1_da, s1_db, s1_l1a, s1_l1b, s1_l2a, s1_l2b;
  logic signed [31:0] s1_f0;
  logic signed [32:0] s1_df1, s1_df2;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_da  <= s0_dx1 * s0_dy2;
      s1_db  <= s0_dx2 * s0_dy1;
      s1_l1a <= s0_dqx * s0_dy2;
      s1_l1b <= s0_dx2 * s0_dqy;
      s1_l2a <= s0_dx1 * s0_dqy;
      s1_l2b <= s0_dqx * s0_dy1;
      s1_f0  <= s0_f0;
      s1_df1 <= s0_df1;
      s1_df2 <= s0_df2;
    end
  end

  // Stage 2: determinant and the two barycentric numerators.
  logic signed [66:0] s2_d, s2_l1, s2_l2;
  logic signed [31:0] s2_f0;
  logic signed [32:0] s2_df1, s2_df2;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_d   <= {s1_da[65], s1_da} - {s1_db[65], s1_db};
      s2_l1  <= {s1_l1a[65], s1_l1a} - {s1_l1b[65], s1_l1b};
      s2_l2  <= {s1_l2a[65], s1_l2a} - {s1_l2b[65], s1_l2b};
      s2_f0  <= s1_f0;
      s2_df1 <= s1_df1;
      s2_df2 <= s1_df2;
    end
  end

  // Stage 3: the wide products are split into a low unsigned and a high signed part.
  logic signed [34:0] d_lo, l1_lo, l2_lo;
  logic signed [32:0] d_hi, l1_hi, l2_hi;
  logic signed [66:0] m0l;
  logic signed [67:0] m1l, m2l;
  logic signed [64:0] m0h;
  logic signed [65:0] m1h, m2h;
  logic [66:0] abs_d;
  logic degen_c;

  assign d_lo  = $signed({1'b0, s2_d[33:0]});
  assign l1_lo = $signed({1'b0, s2_l1[33:0]});
  assign l2_lo = $signed({1'b0, s2_l2[33:0]});
  assign d_hi  = s2_d[66:34];
  assign l1_hi = s2_l1[66:34];
  assign l2_hi = s2_l2[66:34];
  assign m0l   = s2_f0 * d_lo;
  assign m1l   = s2_df1 * l1_lo;
  assign m2l   = s2_df2 * l2_lo;
  assign m0h   = s2_f0 * d_hi;
  assign m1h   = s2_df1 * l1_hi;
  assign m2h   = s2_df2 * l2_hi;
  assign abs_d = s2_d[66] ? 67'(-s2_d) : s2_d;
  assign degen_c = (abs_d == '0) || ((abs_d[66:32] == '0) && (abs_d[31:0] < thr));

  logic signed [69:0] s3_pl0, s3_pl1, s3_pl2;
  logic signed [67:0] s3_ph0, s3_ph1, s3_ph2;
  logic [66:0] s3_absd;
  logic s3_dneg, s3_degen;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_pl0   <= {{3{m0l[66]}}, m0l};
      s3_pl1   <= {{2{m1l[67]}}, m1l};
      s3_pl2   <= {{2{m2l[67]}}, m2l};
      s3_ph0   <= {{3{m0h[64]}}, m0h};
      s3_ph1   <= {{2{m1h[65]}}, m1h};
      s3_ph2   <= {{2{m2h[65]}}, m2h};
      s3_absd  <= abs_d;
      s3_dneg  <= s2_d[66];
      s3_degen <= degen_c;
    end
  end

  // Stage 4: sum the low and high halves separately.
  logic signed [69:0] s4_lo;
  logic signed [67:0] s4_hi;
  logic [66:0] s4_absd;
  logic s4_dneg, s4_degen;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_lo    <= s3_pl0 + s3_pl1 + s3_pl2;
      s4_hi    <= s3_ph0 + s3_ph1 + s3_ph2;
      s4_absd  <= s3_absd;
      s4_dneg  <= s3_dneg;
      s4_degen <= s3_degen;
    end
  end

  // Stage 5: recombine into the full numerator.
  logic signed [101:0] s5_n;
  logic [66:0] s5_absd;
  logic s5_dneg, s5_degen;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_n     <= $signed({s4_hi, 34'b0}) + $signed({{32{s4_lo[69]}}, s4_lo});
      s5_absd  <= s4_absd;
      s5_dneg  <= s4_dneg;
      s5_degen <= s4_degen;
    end
  end

  // Stage 6: magnitude of the numerator and sign of the quotient.
  logic [101:0] s6_absn;
  logic [66:0] s6_absd;
  logic s6_neg, s6_degen;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_absn  <= s5_n[101] ? 102'(-s5_n) : s5_n;
      s6_absd  <= s5_absd;
      s6_neg   <= s5_n[101] ^ s5_dneg;
      s6_degen <= s5_degen;
    end
  end

  // Stage 7: rounding offset, half away from zero: (2|N| + |D|) / (2|D|).
  logic [tli_pkg::DIV_N_W-1:0] s7_nn;
  logic [tli_pkg::DIV_D_W-1:0] s7_dd;
  logic s7_neg, s7_degen;

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_nn    <= {1'b0, s6_absn, 1'b0} + {37'b0, s6_absd};
      s7_dd    <= {s6_absd, 1'b0};
      s7_neg   <= s6_neg;
      s7_degen <= s6_degen;
    end
  end

  // Stage 8 and the divider: dv[0] holds the overflow check, dv[j] quotient bit 32-j.
  tli_pkg::div_t dv [0:tli_pkg::Q_W];

  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0].rem   <= s7_nn;
      dv[0].dd    <= s7_dd;
      dv[0].q     <= '0;
      dv[0].neg   <= s7_neg;
      dv[0].degen <= s7_degen;
      dv[0].ovf   <= s7_nn >= {4'b0, s7_dd, 32'b0};
    end
  end

  for (genvar j = 1; j <= tli_pkg::Q_W; j++) begin : g_div
    localparam int unsigned K = tli_pkg::Q_W - j;
    logic [tli_pkg::DIV_N_W-1:0] sh;
    logic [tli_pkg::DIV_N_W:0]   diff;
    tli_pkg::div_t               dv_next;

    assign sh   = {{(tli_pkg::DIV_N_W - tli_pkg::DIV_D_W){1'b0}}, dv[j-1].dd} << K;
    assign diff = {1'b0, dv[j-1].rem} - {1'b0, sh};

    always_comb begin
      dv_next = dv[j-1];
      if (!diff[tli_pkg::DIV_N_W]) begin
        dv_next.rem  = diff[tli_pkg::DIV_N_W-1:0];
        dv_next.q[K] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv[j] <= dv_next;
      end
    end
  end

  // Final saturation and the degenerate override.
  tli_pkg::div_t fin;
  logic [31:0] res;
  logic inc;

  assign fin = dv[tli_pkg::Q_W];
  assign inc = v[tli_pkg::PIPE_STAGES-1] && adv;

  always_comb begin
    if (fin.degen) begin
      res = '0;
    end else if (fin.ovf) begin
      res = fin.neg ? tli_pkg::SAT_NEG : tli_pkg::SAT_POS;
    end else if (!fin.neg) begin
      res = fin.q[31] ? tli_pkg::SAT_POS : fin.q;
    end else begin
      res = (fin.q > tli_pkg::SAT_NEG) ? tli_pkg::SAT_NEG : 32'(-fin.q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid   <= skid_valid || inc;
      skid_valid <= 1'b0;
    end else if (inc) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tdata <= skid_data;
        m_tuser <= skid_user;
      end else begin
        m_tdata <= res;
        m_tuser <= fin.degen;
      end
    end else if (inc) begin
      skid_data <= res;
      skid_user <= fin.degen;
    end
  end

`ifndef ASSERT_OFF
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("degenerate item carries a nonzero value");

  a_skid_only_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid register holds an item while the output is empty");

  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |=> thr == $past(cfg_data))
    else $error("threshold write was lost");

  a_div_remainder: assert property (@(posedge clk) disable iff (rst)
    v[tli_pkg::PIPE_STAGES-1] && !fin.ovf && !fin.degen
      |-> fin.rem < {{(tli_pkg::DIV_N_W - tli_pkg::DIV_D_W){1'b0}}, fin.dd})
    else $error("divider remainder not below divisor");
`endif

endmodule
